// ===== rtl/lcdns_pkg.sv =====
// shared types, opcodes and constant tables of the lcd nibble sequencer
`timescale 1ns / 1ps
package lcdns_pkg;

  localparam int OPC_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int NUM_W   = 16;
  localparam int NIB_W   = 4;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 3;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 8;

  localparam logic [OPC_W-1:0] OPC_INIT   = 3'd0;
  localparam logic [OPC_W-1:0] OPC_CMD    = 3'd1;
  localparam logic [OPC_W-1:0] OPC_DATA   = 3'd2;
  localparam logic [OPC_W-1:0] OPC_NUMBER = 3'd3;
  localparam logic [OPC_W-1:0] OPC_CURSOR = 3'd4;

  localparam logic [BYTE_W-1:0] ROW1_BASE  = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_BASE  = 8'hC0;
  localparam logic [NIB_W-1:0]  ASCII_HIGH = 4'h3;
  localparam logic [CNT_W-1:0]  INIT_LAST  = 4'd11;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_BYTE,
    KIND_NUM
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   rs;
    logic [BYTE_W-1:0]      byte_val;
    logic [NUM_W-1:0]       number;
    logic [IDX_W-1:0]       top_idx;   // power of ten of the leading digit
  } entry_t;

  // wake-up nibbles, function set, display off, display on, clear
  function automatic logic [NIB_W-1:0] init_nibble(input logic [CNT_W-1:0] idx);
    logic [NIB_W-1:0] nib;
    case (idx)
      4'd0:    nib = 4'h3;
      4'd1:    nib = 4'h3;
      4'd2:    nib = 4'h3;
      4'd3:    nib = 4'h2;
      4'd4:    nib = 4'h2;
      4'd5:    nib = 4'h8;
      4'd6:    nib = 4'h0;
      4'd7:    nib = 4'h8;
      4'd8:    nib = 4'h0;
      4'd9:    nib = 4'hC;
      4'd10:   nib = 4'h0;
      4'd11:   nib = 4'h1;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [13:0] pow10(input logic [IDX_W-1:0] idx);
    logic [13:0] p;
    case (idx)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/lcdns_front.sv =====
// front end: accepts request beats, drops unknown opcodes, builds queue entries
`timescale 1ns / 1ps
module lcdns_front
  import lcdns_pkg::*;
(
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,
  input  logic            q_full_i,
  output logic            q_push_o,
  output entry_t          q_entry_o
);

  logic [OPC_W-1:0]  opcode;
  logic [BYTE_W-1:0] byte_value;
  logic [NUM_W-1:0]  number;
  logic [BYTE_W-1:0] column;
  logic [BYTE_W-1:0] row;
  logic [BYTE_W-1:0] base;
  logic              known;

  assign opcode     = s_axis_tdata[2:0];
  assign byte_value = s_axis_tdata[10:3];
  assign number     = s_axis_tdata[26:11];
  assign column     = s_axis_tdata[34:27];
  assign row        = s_axis_tdata[42:35];

  assign base = (row == 8'd1) ? ROW1_BASE : ROW2_BASE;

  always_comb begin
    q_entry_o          = '0;
    q_entry_o.kind     = KIND_BYTE;
    q_entry_o.byte_val = byte_value;
    q_entry_o.number   = number;
    known              = 1'b1;
    case (opcode)
      OPC_INIT: begin
        q_entry_o.kind = KIND_INIT;
      end
      OPC_CMD: begin
        q_entry_o.rs = 1'b0;
      end
      OPC_DATA: begin
        q_entry_o.rs = 1'b1;
      end
      OPC_NUMBER: begin
        q_entry_o.kind = KIND_NUM;
        q_entry_o.rs   = 1'b1;
        if (number >= 16'd10000) begin
          q_entry_o.top_idx = 3'd4;
        end else if (number >= 16'd1000) begin
          q_entry_o.top_idx = 3'd3;
        end else if (number >= 16'd100) begin
          q_entry_o.top_idx = 3'd2;
        end else if (number >= 16'd10) begin
          q_entry_o.top_idx = 3'd1;
        end else begin
          q_entry_o.top_idx = 3'd0;
        end
      end
      OPC_CURSOR: begin
        // address is base plus column minus one, wrapping in 8 bits
        q_entry_o.byte_val = base + column - 8'd1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && known;

endmodule

// ===== rtl/lcdns_queue.sv =====
// small fifo of decoded requests between front and back
`timescale 1ns / 1ps
module lcdns_queue
  import lcdns_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/lcdns_back.sv =====
// back end: walks one queued request and drives one nibble beat per cycle unless the output stalls
`timescale 1ns / 1ps
module lcdns_back
  import lcdns_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  entry_t           q_head_i,
  output logic             q_pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic              act_q, act_d;
  kind_e             kind_q, kind_d;
  logic              rs_q, rs_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              ov_q;
  logic [NIB_W-1:0]  onib_q;
  logic              ors_q, olast_q;

  logic              emit;
  logic [NIB_W-1:0]  nib;
  logic              beat_last;
  logic [13:0]       pw;
  logic [NIB_W-1:0]  digit;
  logic [16:0]       sub;
  logic [16:0]       kp;

  assign emit = act_q && (!ov_q || m_axis_tready);

  // decimal digit of the remainder at the current power, by parallel compares
  always_comb begin
    pw    = pow10(idx_q);
    digit = '0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      kp = 17'(k) * {3'b000, pw};
      if ({1'b0, rem_q} >= kp) begin
        digit = NIB_W'(k);
        sub   = kp;
      end
    end
  end

  always_comb begin
    nib       = '0;
    beat_last = 1'b0;
    case (kind_q)
      KIND_INIT: begin
        nib       = init_nibble(cnt_q);
        beat_last = (cnt_q == INIT_LAST);
      end
      KIND_BYTE: begin
        nib       = cnt_q[0] ? byte_q[3:0] : byte_q[7:4];
        beat_last = cnt_q[0];
      end
      KIND_NUM: begin
        nib       = cnt_q[0] ? digit : ASCII_HIGH;
        beat_last = cnt_q[0] && (idx_q == '0);
      end
      default: begin
        nib       = '0;
        beat_last = 1'b1;
      end
    endcase
  end

  assign q_pop_o = q_valid_i && (!act_q || (emit && beat_last));

  always_comb begin
    act_d  = act_q;
    kind_d = kind_q;
    rs_d   = rs_q;
    byte_d = byte_q;
    rem_d  = rem_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    if (q_pop_o) begin
      act_d  = 1'b1;
      kind_d = q_head_i.kind;
      rs_d   = q_head_i.rs;
      byte_d = q_head_i.byte_val;
      rem_d  = q_head_i.number;
      idx_d  = q_head_i.top_idx;
      cnt_d  = '0;
    end else if (emit) begin
      if (beat_last) begin
        act_d = 1'b0;
      end else if (kind_q == KIND_NUM) begin
        cnt_d = {{(CNT_W-1){1'b0}}, ~cnt_q[0]};
        if (cnt_q[0]) begin
          rem_d = NUM_W'({1'b0, rem_q} - sub);
          idx_d = idx_q - 1'b1;
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rs_q   <= rs_d;
    byte_q <= byte_d;
    rem_q  <= rem_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    if (emit) begin
      onib_q  <= nib;
      ors_q   <= (kind_q == KIND_INIT) ? 1'b0 : rs_q;
      olast_q <= beat_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(OUT_W-NIB_W){1'b0}}, onib_q};
  assign m_axis_tuser  = ors_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// top level of the character lcd nibble sequencer
// Turns requests for a character LCD in 4-bit mode into nibble transfers.
// Input beat (s_axis): opcode init, command byte, data char, decimal number
// or cursor position, with its operands packed in tdata. Unknown opcodes are
// taken and produce nothing. Output beat (m_axis): one nibble transfer, high
// nibble of each byte first; tuser is the register select, tlast marks the
// final transfer of a request.
// Throughput: one output beat per cycle while the receiver is ready. A request
// gives 2 beats (command, char, cursor), 12 (init) or 2 to 10 (number, two per
// printed digit) on the output side; the back end's nibble walk sets these
// counts, and a new request starts in the cycle after the previous one's last
// beat. An input beat passes the queue, request and output registers.
// The front and back are joined by a QUEUE_DEPTH-entry queue, so input beats
// keep being taken while the back end works or the receiver stalls; a stalled
// output holds its beat and backs up the queue, then the input.
// Reset empties the queue and the output register; nothing else is kept.
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer
  import lcdns_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // opcode, byte_value, number, column, row
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // nibble
  output logic             m_axis_tuser,   // reg_select
  output logic             m_axis_tlast
);

  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_in, q_head;

  lcdns_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  lcdns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
